// ----- rtl/hhdm_pkg.sv -----
// ----------------------------------------------------------------------------
// hhdm_pkg
// Shared types and constants of the health history degradation monitor.
// ----------------------------------------------------------------------------
package hhdm_pkg;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [15:0] MARGIN_RESET      = 16'd2560;
	localparam int          DEGRADE_MIN_COUNT = 4;

	typedef struct packed {
		logic        operation;
		logic [15:0] health;
		logic [3:0]  last_n;
	} hhdm_in_t;

	typedef struct packed {
		logic        degraded;
		logic [15:0] avg_health;
		logic [3:0]  record_count;
	} hhdm_out_t;

	typedef struct packed {
		logic load;
		logic rd_step;
		logic div_start;
		logic div_step;
		logic emit;
	} hhdm_cmd_t;

	typedef struct packed {
		logic rd_busy;
		logic div_busy;
		logic query_div;
		logic out_free;
	} hhdm_status_t;

endpackage

// ----- rtl/health_history_degradation_monitor_core.sv -----
// ----------------------------------------------------------------------------
// health_history_degradation_monitor_core
// Ring of recent health scores with degradation flag and averaging query.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready with in_data, results leave on
// out_valid/out_ready with out_data, one result per item. The margin is
// written on cfg_valid/cfg_data; cfg_ready is always high.
// A record beat writes the score into the ring and, once four scores are
// held, reads the three before it one per cycle from the single ring read
// port. A query beat reads the newest n scores the same way and, when n
// clamped to the count is nonzero, runs a restoring divider that retires
// one quotient bit per cycle over 16 + clog2(HISTORY_DEPTH + 1) bits.
// One item is in flight at a time; in_ready rises in the same cycle as
// out_valid, so a new beat is taken only once the last result is emitted.
// Reset clears the pointer, the count, the handshakes and sets the margin
// to 10.0 in Q8.8. When the receiver stalls, the result waits in the output
// register while the next item is already being worked on; that item then
// holds in its final step until the register is free.
// ----------------------------------------------------------------------------
module health_history_degradation_monitor_core #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hhdm_pkg::hhdm_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hhdm_pkg::hhdm_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	hhdm_pkg::hhdm_cmd_t    cmd;
	hhdm_pkg::hhdm_status_t st;

	assign cfg_ready = 1'b1;

	hhdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	hhdm_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_item   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_item  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

// ----- rtl/hhdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// hhdm_ctrl
// Sequencer that steps one item through history reads, division and output.
// ----------------------------------------------------------------------------
module hhdm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hhdm_pkg::hhdm_status_t st,
	output hhdm_pkg::hhdm_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_step = 1'b1;
				if (!st.rd_busy) begin
					if (st.query_div) begin
						cmd.div_start = 1'b1;
						state_nxt     = ST_DIV;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (!st.div_busy) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A result is only loaded into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result loaded into an occupied output register");

	// The datapath is quiet whenever a new item may enter.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!st.rd_busy && !st.div_busy))
		else $error("new item accepted while datapath is busy");

	// After a result is handed over, the block is ready for the next item.
	a_emit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> in_ready)
		else $error("block not ready after emitting a result");

endmodule

// ----- rtl/hhdm_dp.sv -----
// ----------------------------------------------------------------------------
// hhdm_dp
// Score ring, accumulator, restoring divider, margin and output register.
// ----------------------------------------------------------------------------
module hhdm_dp #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hhdm_pkg::hhdm_cmd_t    cmd,
	output hhdm_pkg::hhdm_status_t st,
	input  hhdm_pkg::hhdm_in_t     in_item,
	input  logic                   cfg_valid,
	input  logic [15:0]            cfg_data,
	output hhdm_pkg::hhdm_out_t    out_item,
	output logic                   out_valid,
	input  logic                   out_ready
);

	localparam int PW    = $clog2(HISTORY_DEPTH);
	localparam int CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int ACC_W = 16 + CW;
	localparam int DCW   = $clog2(ACC_W + 1);
	localparam int CMP_W = ACC_W + 3;

	logic [15:0]      ring_q [HISTORY_DEPTH];
	logic [15:0]      rdata_s1;
	logic             pend_s1;
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    reads_q;
	logic [CW-1:0]    n_q;
	logic             op_q;
	logic [15:0]      cur_q;
	logic [15:0]      margin_q;
	logic [ACC_W-1:0] acc_q;
	logic [CW-1:0]    rem_q;
	logic [DCW-1:0]   div_cnt_q;
	hhdm_pkg::hhdm_out_t out_q;
	logic             out_valid_q;

	logic             rd_issue;
	logic [CW-1:0]    count_inc;
	logic [CW-1:0]    n_clamp;
	logic [PW-1:0]    wp_prev;
	logic [PW-1:0]    wp_next;
	logic [PW-1:0]    rd_prev;
	logic [CW:0]      trial;
	logic [CW:0]      diff;
	logic             q_bit;
	logic [18:0]      thr;
	logic [7:0]       count_ext;
	logic             is_record;

	assign is_record = (in_item.operation == hhdm_pkg::OP_RECORD);
	assign rd_issue  = cmd.rd_step && (reads_q != '0);
	assign count_inc = (count_q == CW'(HISTORY_DEPTH)) ? count_q : count_q + CW'(1);
	assign n_clamp   = (8'(in_item.last_n) > 8'(count_q)) ? count_q
	                 : CW'(in_item.last_n);
	assign wp_prev   = (wp_q == '0) ? PW'(HISTORY_DEPTH - 1) : wp_q - PW'(1);
	assign wp_next   = (wp_q == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + PW'(1);
	assign rd_prev   = (rd_ptr_q == '0) ? PW'(HISTORY_DEPTH - 1) : rd_ptr_q - PW'(1);

	assign trial = {rem_q, acc_q[ACC_W-1]};
	assign diff  = trial - {1'b0, n_q};
	assign q_bit = (trial >= {1'b0, n_q});

	assign thr = 19'(cur_q) + 19'(cur_q) + 19'(cur_q)
	           + 19'(margin_q) + 19'(margin_q) + 19'(margin_q);
	assign count_ext = 8'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load && is_record) begin
			ring_q[wp_q] <= in_item.health;
		end
		if (rd_issue) begin
			rdata_s1 <= ring_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			count_q   <= '0;
			reads_q   <= '0;
			pend_s1   <= 1'b0;
			div_cnt_q <= '0;
			margin_q  <= hhdm_pkg::MARGIN_RESET;
		end else begin
			if (cfg_valid) begin
				margin_q <= cfg_data;
			end
			pend_s1 <= rd_issue;
			if (cmd.load) begin
				if (is_record) begin
					wp_q    <= wp_next;
					count_q <= count_inc;
					reads_q <= (count_inc >= CW'(hhdm_pkg::DEGRADE_MIN_COUNT))
					         ? CW'(3) : '0;
				end else begin
					reads_q <= n_clamp;
				end
			end else if (rd_issue) begin
				reads_q <= reads_q - CW'(1);
			end
			if (cmd.div_start) begin
				div_cnt_q <= DCW'(ACC_W);
			end else if (cmd.div_step && (div_cnt_q != '0)) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_item.operation;
			cur_q    <= in_item.health;
			n_q      <= n_clamp;
			rd_ptr_q <= wp_prev;
			acc_q    <= '0;
		end else if (rd_issue) begin
			rd_ptr_q <= rd_prev;
		end
		if (pend_s1) begin
			acc_q <= acc_q + ACC_W'(rdata_s1);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end else if (cmd.div_step && (div_cnt_q != '0)) begin
			rem_q <= q_bit ? diff[CW-1:0] : trial[CW-1:0];
			acc_q <= {acc_q[ACC_W-2:0], q_bit};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.degraded     <= (op_q == hhdm_pkg::OP_RECORD)
			                   && (CMP_W'(acc_q) > CMP_W'(thr));
			out_q.avg_health   <= (op_q == hhdm_pkg::OP_QUERY) ? acc_q[15:0] : 16'd0;
			out_q.record_count <= count_ext[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_item     = out_q;
	assign out_valid    = out_valid_q;
	assign st.rd_busy   = (reads_q != '0) || pend_s1;
	assign st.div_busy  = (div_cnt_q != '0);
	assign st.query_div = (op_q == hhdm_pkg::OP_QUERY) && (n_q != '0);
	assign st.out_free  = !out_valid_q || out_ready;

endmodule

// ----- test/health_monitor_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// health_monitor_checker
// Watches the item, result and margin channels of the health history monitor.
// It keeps its own score ring, pointer, count and margin, predicts the report
// of every accepted item and compares each delivered report field by field
// against the oldest prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module health_monitor_checker #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  hhdm_pkg::hhdm_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  hhdm_pkg::hhdm_out_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [15:0]         cfg_data,
	output int                  pending,
	output int                  mismatches
);

	logic [15:0]         score_history [HISTORY_DEPTH];
	int                  next_slot = 0;
	int                  held = 0;
	logic [15:0]         margin = hhdm_pkg::MARGIN_RESET;
	hhdm_pkg::hhdm_out_t predicted_reports [$];
	int                  backlog = 0;
	int                  errors = 0;

	assign pending    = backlog;
	assign mismatches = errors;

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s, got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int slot_back(input int steps);
		return (next_slot + HISTORY_DEPTH - 1 - steps) % HISTORY_DEPTH;
	endfunction

	function automatic hhdm_pkg::hhdm_out_t history_step(input hhdm_pkg::hhdm_in_t item);
		hhdm_pkg::hhdm_out_t report;
		logic [31:0]         total;
		logic [31:0]         newest;
		int                  span;
		int                  i;
		report = '0;
		if (item.operation == hhdm_pkg::OP_RECORD) begin
			score_history[next_slot] = item.health;
			next_slot = (next_slot + 1) % HISTORY_DEPTH;
			if (held < HISTORY_DEPTH)
				held++;
			if (held >= hhdm_pkg::DEGRADE_MIN_COUNT) begin
				newest = 32'(score_history[slot_back(0)]);
				total  = 32'(score_history[slot_back(1)]) + 32'(score_history[slot_back(2)])
					+ 32'(score_history[slot_back(3)]);
				report.degraded = (total > 32'd3 * newest + 32'd3 * 32'(margin));
			end
		end else if (held != 0 && item.last_n != 0) begin
			span  = (int'(item.last_n) > held) ? held : int'(item.last_n);
			total = '0;
			for (i = 0; i < span; i++)
				total += 32'(score_history[slot_back(i)]);
			report.avg_health = 16'(total / 32'(span));
		end
		report.record_count = 4'(held);
		return report;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hhdm_pkg::hhdm_out_t want;
		if (!arst_n) begin
			next_slot = 0;
			held      = 0;
			margin    = hhdm_pkg::MARGIN_RESET;
			predicted_reports.delete();
			backlog   = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				margin = cfg_data;
			if (out_valid && out_ready) begin
				if (predicted_reports.size() == 0) begin
					flag_mismatch("report with no item outstanding", int'(out_data), 0);
				end else begin
					want = predicted_reports.pop_front();
					if (out_data.degraded !== want.degraded)
						flag_mismatch("degraded", int'(out_data.degraded), int'(want.degraded));
					if (out_data.avg_health !== want.avg_health)
						flag_mismatch("avg_health", int'(out_data.avg_health),
							int'(want.avg_health));
					if (out_data.record_count !== want.record_count)
						flag_mismatch("record_count", int'(out_data.record_count),
							int'(want.record_count));
				end
			end
			if (in_valid && in_ready)
				predicted_reports.push_back(history_step(in_data));
			backlog = predicted_reports.size();
		end
	end

endmodule

// ----- test/health_history_degradation_monitor_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// health_history_degradation_monitor_core_tb
// Regression of the health history degradation monitor.
// A directed opening covers empty queries, the four-score threshold, count
// saturation with ring wrap, clamping of n and the exact margin boundary.
// Random items then run under several margins, drifting around a score level
// with drops near the margin, with random gaps and stalls on both channels,
// a long receiver hold-off and drains before every margin change.
// ----------------------------------------------------------------------------
module health_history_degradation_monitor_core_tb;

	localparam int DEPTH = 10;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	hhdm_pkg::hhdm_in_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	hhdm_pkg::hhdm_out_t out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [15:0]         cfg_data = '0;
	int                  pending;
	int                  mismatches;

	bit          send_idles = 1'b1;
	bit          recv_idles = 1'b1;
	int          hold_cycles = 0;
	int          level = 16000;
	int          margin_now = int'(hhdm_pkg::MARGIN_RESET);

	always #4 clk = ~clk;

	health_history_degradation_monitor_core #(
		.HISTORY_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	health_monitor_checker #(
		.HISTORY_DEPTH(DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.mismatches(mismatches)
	);

	task automatic offer_item(input hhdm_pkg::hhdm_in_t item);
		int gap;
		gap = send_idles ? int'($urandom_range(0, 7)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic record_score(input logic [15:0] score);
		hhdm_pkg::hhdm_in_t item;
		item.operation = hhdm_pkg::OP_RECORD;
		item.health    = score;
		item.last_n    = 4'($urandom_range(0, 15));
		offer_item(item);
	endtask

	task automatic query_average(input logic [3:0] span);
		hhdm_pkg::hhdm_in_t item;
		item.operation = hhdm_pkg::OP_QUERY;
		item.health    = 16'($urandom);
		item.last_n    = span;
		offer_item(item);
	endtask

	task automatic offer_random_item();
		hhdm_pkg::hhdm_in_t item;
		int                 pick;
		int                 score;
		item.operation = ($urandom_range(0, 99) < 55) ? hhdm_pkg::OP_RECORD
		               : hhdm_pkg::OP_QUERY;
		item.health    = 16'($urandom);
		item.last_n    = 4'($urandom_range(0, 15));
		if (item.operation == hhdm_pkg::OP_RECORD) begin
			pick = int'($urandom_range(0, 9));
			if (pick == 0)
				level = int'($urandom_range(0, 65535));
			if (pick == 1)
				score = $urandom_range(0, 1) ? 65535 : 0;
			else if (pick <= 4)
				score = level - margin_now - int'($urandom_range(0, 4)) + 2;
			else if (pick <= 8)
				score = level + int'($urandom_range(0, 512)) - 256;
			else
				score = int'($urandom_range(0, 65535));
			if (score < 0)
				score = 0;
			if (score > 65535)
				score = 65535;
			item.health = 16'(score);
		end
		offer_item(item);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_margin(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		margin_now = int'(value);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = recv_idles ? int'($urandom_range(0, 7)) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [15:0] margins [5];
		int          phase;
		int          k;
		margins = '{hhdm_pkg::MARGIN_RESET, 16'h0000, 16'hFFFF, 16'($urandom), 16'h0100};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		query_average(4'd0);
		query_average(4'd15);
		record_score(16'hFFFF);
		record_score(16'h0000);
		record_score(16'hFFFF);
		query_average(4'd15);
		record_score(16'hFFFF);
		record_score(16'h0000);
		query_average(4'd0);
		query_average(4'd1);
		// Three scores of 3560 then 1000 land exactly on the default margin.
		record_score(16'd3560);
		record_score(16'd3560);
		record_score(16'd3560);
		record_score(16'd1000);
		record_score(16'hFFFF);
		record_score(16'hFFFF);
		record_score(16'hFFFF);
		query_average(4'd10);
		query_average(4'd15);
		query_average(4'd9);
		record_score(16'h5A5A);
		drain();

		for (phase = 0; phase < 5; phase++) begin
			if (phase != 0)
				write_margin(margins[phase]);
			for (k = 0; k < 76; k++) begin
				if (k % 19 == 0) begin
					send_idles = ($urandom_range(0, 2) != 0);
					recv_idles = ($urandom_range(0, 2) != 0);
				end
				if (phase == 3 && k == 20)
					hold_cycles = 300;
				offer_random_item();
			end
			drain();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
